[src/lzhc_pkg.sv]
`timescale 1ns / 1ps
package lzhc_pkg;
	localparam int WIN_BYTES_D     = 32768;
	localparam int HASH_ENTRIES_D  = 32768;
	localparam int HISTORY_BYTES_D = 65536;
	localparam int MIN_RUN         = 3;
	localparam int RUN_CAP_D       = 258;
	localparam int HASH_BITS       = 15;
	localparam int HASH_SHIFT      = 17;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	localparam logic [31:0] NULL_LINK = 32'hFFFF_FFFF;
	localparam logic [12:0] MAX_CHAIN_RST = 13'd128;

	typedef enum logic [2:0] {
		MODE_LOAD   = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_FINDI  = 3'd2,
		MODE_FIND   = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLEAR, ST_LOAD, ST_HRD0, ST_HRD1, ST_HRD2, ST_HRD3,
		ST_HASH, ST_HEAD, ST_HEADW, ST_CAND, ST_CMPA, ST_CMPB, ST_CMPC,
		ST_NEXT, ST_LINK, ST_DONE
	} state_t;

	function automatic logic [HASH_BITS-1:0] hash_fn(input logic [31:0] prod);
		hash_fn = prod[31:HASH_SHIFT];
	endfunction
endpackage

[src/lz77_hash_chain_match_finder.sv]
`timescale 1ns / 1ps
// channel | dir | handshake               | payload
// in      | in  | in_valid / in_ready     | mode, position, byte_value, available
// out     | out | out_valid / out_ready   | found, match_len, match_distance
// cfg     | in  | cfg_valid / cfg_ready   | cfg_data (max_chain)
// A load writes a byte into the history ring. An insert hashes three history bytes and
// links the position into the head and chain tables; a find hashes them, walks the chain
// and compares a byte at a time over the one history read port (MODE_FINDI links first).
// After reset or a clear, a sweep nulls both tables; no item is taken meanwhile.
// A result waits in the output register; the next item is taken while it waits, and a
// find holds in its last state until the previous result has been taken.
module lz77_hash_chain_match_finder #(
	parameter int WIN_BYTES     = lzhc_pkg::WIN_BYTES_D,
	parameter int HISTORY_BYTES = lzhc_pkg::HISTORY_BYTES_D,
	parameter int RUN_CAP       = lzhc_pkg::RUN_CAP_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] position,
	input  logic [7:0]  byte_value,
	input  logic [8:0]  available,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [8:0]  match_len,
	output logic [15:0] match_distance,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data
);
	localparam int HB = lzhc_pkg::HASH_BITS;
	localparam int RB = $clog2(HISTORY_BYTES);
	localparam int CB = $clog2(WIN_BYTES);

	lzhc_pkg::state_t st_q, st_d;
	logic [12:0] max_chain_q;
	logic [2:0]  mode_q;
	logic [31:0] pos_q, cand_q;
	logic [7:0]  byte_q, b0_q, b1_q, pb_q;
	logic [8:0]  limit_q, n_q, best_len_q;
	logic [15:0] best_dist_q;
	logic [31:0] prod_q;
	logic [HB-1:0] hash_q;
	logic [12:0] cnt_q;
	logic [HB:0] clr_q;
	logic        ins_q;

	logic ov_q, of_q;
	logic [8:0]  ol_q;
	logic [15:0] od_q;

	logic        h_we, c_we, r_we;
	logic [HB-1:0] h_wa, h_ra;
	logic [CB-1:0] c_wa, c_ra;
	logic [31:0] h_wd, c_wd, h_rd, c_rd;
	logic [RB-1:0] r_a;
	logic [7:0]  r_rd;
	logic [7:0]  ring [HISTORY_BYTES];

	lzhc_ram #(.DEPTH(lzhc_pkg::HASH_ENTRIES_D), .WIDTH(32)) u_head (
		.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	lzhc_ram #(.DEPTH(WIN_BYTES), .WIDTH(32)) u_chain (
		.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

	always_ff @(posedge clk) begin
		if (r_we)
			ring[r_a] <= byte_q;
		r_rd <= ring[r_a];
	end

	logic [31:0] dist_w;
	logic        busy_out;
	assign dist_w   = pos_q - cand_q;
	assign busy_out = ov_q && !out_ready;
	assign in_ready  = (st_q == lzhc_pkg::ST_IDLE);
	assign cfg_ready = (st_q == lzhc_pkg::ST_IDLE) && !in_valid;
	assign out_valid = ov_q;
	assign found = of_q;
	assign match_len = ol_q;
	assign match_distance = od_q;

	always_comb begin
		st_d = st_q;
		h_we = 1'b0; c_we = 1'b0; r_we = 1'b0;
		h_wa = hash_q; h_wd = pos_q; h_ra = hash_q;
		c_wa = pos_q[CB-1:0]; c_wd = h_rd; c_ra = cand_q[CB-1:0];
		r_a  = pos_q[RB-1:0];
		case (st_q)
			lzhc_pkg::ST_CLEAR: begin
				h_we = !clr_q[HB]; c_we = !clr_q[HB] && (clr_q < (HB+1)'(WIN_BYTES));
				h_wa = clr_q[HB-1:0]; h_wd = lzhc_pkg::NULL_LINK;
				c_wa = clr_q[CB-1:0]; c_wd = lzhc_pkg::NULL_LINK;
				if (clr_q[HB]) st_d = lzhc_pkg::ST_IDLE;
			end
			lzhc_pkg::ST_IDLE: if (in_valid) begin
				case (mode)
					lzhc_pkg::MODE_LOAD:  st_d = lzhc_pkg::ST_LOAD;
					lzhc_pkg::MODE_CLEAR: st_d = lzhc_pkg::ST_CLEAR;
					lzhc_pkg::MODE_INSERT: st_d = (available >= 9'(lzhc_pkg::MIN_RUN)) ?
						lzhc_pkg::ST_HRD0 : lzhc_pkg::ST_IDLE;
					lzhc_pkg::MODE_FINDI, lzhc_pkg::MODE_FIND:
						st_d = (available >= 9'(lzhc_pkg::MIN_RUN)) ?
							lzhc_pkg::ST_HRD0 : lzhc_pkg::ST_DONE;
					default: st_d = lzhc_pkg::ST_IDLE;
				endcase
			end
			lzhc_pkg::ST_LOAD: begin r_we = 1'b1; st_d = lzhc_pkg::ST_IDLE; end
			lzhc_pkg::ST_HRD0: begin r_a = pos_q[RB-1:0]; st_d = lzhc_pkg::ST_HRD1; end
			lzhc_pkg::ST_HRD1: begin r_a = RB'(pos_q + 32'd1); st_d = lzhc_pkg::ST_HRD2; end
			lzhc_pkg::ST_HRD2: begin r_a = RB'(pos_q + 32'd2); st_d = lzhc_pkg::ST_HRD3; end
			lzhc_pkg::ST_HRD3: st_d = lzhc_pkg::ST_HASH;
			lzhc_pkg::ST_HASH: st_d = lzhc_pkg::ST_HEAD;
			lzhc_pkg::ST_HEAD: st_d = lzhc_pkg::ST_HEADW;
			lzhc_pkg::ST_HEADW: begin
				if (ins_q) begin
					h_we = 1'b1; c_we = 1'b1;
				end
				st_d = (mode_q == lzhc_pkg::MODE_INSERT) ? lzhc_pkg::ST_IDLE : lzhc_pkg::ST_CAND;
			end
			lzhc_pkg::ST_CAND: begin
				if (cnt_q >= max_chain_q || cand_q == lzhc_pkg::NULL_LINK || cand_q > pos_q
				    || dist_w > 32'(WIN_BYTES))
					st_d = lzhc_pkg::ST_DONE;
				else
					st_d = lzhc_pkg::ST_CMPA;
			end
			lzhc_pkg::ST_CMPA: begin
				r_a = RB'(pos_q + 32'(n_q));
				st_d = (n_q < limit_q) ? lzhc_pkg::ST_CMPB : lzhc_pkg::ST_NEXT;
			end
			lzhc_pkg::ST_CMPB: begin r_a = RB'(cand_q + 32'(n_q)); st_d = lzhc_pkg::ST_CMPC; end
			lzhc_pkg::ST_CMPC: st_d = (pb_q == r_rd) ? lzhc_pkg::ST_CMPA : lzhc_pkg::ST_NEXT;
			lzhc_pkg::ST_NEXT: begin
				if (n_q > best_len_q && n_q == 9'(RUN_CAP)) st_d = lzhc_pkg::ST_DONE;
				else st_d = lzhc_pkg::ST_LINK;
			end
			lzhc_pkg::ST_LINK: st_d = lzhc_pkg::ST_CAND;
			lzhc_pkg::ST_DONE: if (!busy_out) st_d = lzhc_pkg::ST_IDLE;
			default: st_d = lzhc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lzhc_pkg::ST_CLEAR;
			clr_q <= '0;
			max_chain_q <= lzhc_pkg::MAX_CHAIN_RST;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) max_chain_q <= cfg_data;
			if (st_q == lzhc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (st_q == lzhc_pkg::ST_DONE && !busy_out) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			lzhc_pkg::ST_IDLE: begin
				mode_q <= mode; pos_q <= position; byte_q <= byte_value;
				limit_q <= (available < 9'(RUN_CAP)) ? available : 9'(RUN_CAP);
				ins_q <= (mode == lzhc_pkg::MODE_INSERT) || (mode == lzhc_pkg::MODE_FINDI);
				best_len_q <= 9'(lzhc_pkg::MIN_RUN - 1);
				best_dist_q <= '0; cnt_q <= '0;
			end
			lzhc_pkg::ST_HRD1: b0_q <= r_rd;
			lzhc_pkg::ST_HRD2: b1_q <= r_rd;
			lzhc_pkg::ST_HRD3: prod_q <= {8'd0, b0_q, b1_q, r_rd} * lzhc_pkg::HASH_MULT;
			lzhc_pkg::ST_HASH: hash_q <= lzhc_pkg::hash_fn(prod_q);
			lzhc_pkg::ST_HEADW: begin cand_q <= h_rd; n_q <= '0; end
			lzhc_pkg::ST_CAND: n_q <= '0;
			lzhc_pkg::ST_CMPB: pb_q <= r_rd;
			lzhc_pkg::ST_CMPC: if (pb_q == r_rd) n_q <= n_q + 9'd1;
			lzhc_pkg::ST_NEXT: begin
				if (n_q > best_len_q) begin
					best_len_q <= n_q; best_dist_q <= 16'(dist_w);
				end
				cnt_q <= cnt_q + 13'd1;
			end
			lzhc_pkg::ST_LINK: cand_q <= c_rd;
			lzhc_pkg::ST_DONE: if (!busy_out) begin
				if (best_dist_q == 16'd0) begin
					of_q <= 1'b0; ol_q <= '0; od_q <= '0;
				end else begin
					of_q <= 1'b1; ol_q <= best_len_q; od_q <= best_dist_q;
				end
			end
			default: ;
		endcase
	end

	// ST_LINK reads chain at cand slot issued during ST_NEXT
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> match_len >= 9'(lzhc_pkg::MIN_RUN))
		else $error("short match reported");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> in_ready) else $error("cfg while busy");
endmodule

[src/lzhc_ram.sv]
`timescale 1ns / 1ps
module lzhc_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[verif/tb_lz77_hash_chain_match_finder.sv]
`timescale 1ns / 1ps
module tb_lz77_hash_chain_match_finder;

	typedef struct {
		bit          is_cfg;
		logic [12:0] chain_cap;
		logic [2:0]  md;
		logic [31:0] pos;
		logic [7:0]  bv;
		logic [8:0]  av;
	} op_t;

	typedef struct packed {
		logic        found;
		logic [8:0]  len;
		logic [15:0] mdist;
	} match_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = '0;
	logic [31:0] position = '0;
	logic [7:0]  byte_value = '0;
	logic [8:0]  available = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [8:0]  match_len;
	logic [15:0] match_distance;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = '0;

	op_t         pending_ops[$];
	match_t      expected_matches[$];
	logic [31:0] heads[lzhc_pkg::HASH_ENTRIES_D];
	logic [31:0] links[32768];
	logic [7:0]  hist[lzhc_pkg::HISTORY_BYTES_D];
	logic [12:0] chain_cap = lzhc_pkg::MAX_CHAIN_RST;
	int          errors = 0;
	bit          gen_done = 0;
	bit          sent_all = 0;
	bit          in_took = 0;
	bit          cfg_took = 0;

	lz77_hash_chain_match_finder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .position(position), .byte_value(byte_value), .available(available),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .match_len(match_len), .match_distance(match_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic logic [14:0] hash3(input logic [31:0] p);
		logic [31:0] a1, a2, v, pr;
		a1 = p + 32'd1;
		a2 = p + 32'd2;
		v = {8'd0, hist[p[15:0]], hist[a1[15:0]], hist[a2[15:0]]};
		pr = v * lzhc_pkg::HASH_MULT;
		return pr[31:17];
	endfunction

	function automatic void wipe_tables();
		for (int i = 0; i < 32768; i++) begin
			heads[i] = lzhc_pkg::NULL_LINK;
			links[i] = lzhc_pkg::NULL_LINK;
		end
	endfunction

	function automatic match_t find_longest(input logic [31:0] p, input logic [8:0] av,
			input bit ins);
		logic [14:0] h;
		logic [31:0] c, d, bl, bd, lim, n, pa, ca;
		match_t r;
		r = '0;
		if (av < lzhc_pkg::MIN_RUN) return r;
		h = hash3(p);
		c = heads[h];
		if (ins) begin
			links[p[14:0]] = c;
			heads[h] = p;
		end
		bl = lzhc_pkg::MIN_RUN - 1;
		bd = 0;
		lim = (av < lzhc_pkg::RUN_CAP_D) ? av : lzhc_pkg::RUN_CAP_D;
		for (int i = 0; i < chain_cap && c != lzhc_pkg::NULL_LINK; i++) begin
			if (c > p) break;
			d = p - c;
			if (d > lzhc_pkg::WIN_BYTES_D) break;
			n = 0;
			while (n < lim) begin
				pa = p + n;
				ca = c + n;
				if (hist[pa[15:0]] != hist[ca[15:0]]) break;
				n++;
			end
			if (n > bl) begin
				bl = n;
				bd = d;
				if (bl == lzhc_pkg::RUN_CAP_D) break;
			end
			c = links[c[14:0]];
		end
		if (bd != 0) r = {1'b1, bl[8:0], bd[15:0]};
		return r;
	endfunction

	function automatic void apply_item(input logic [2:0] md, input logic [31:0] p,
			input logic [7:0] bv, input logic [8:0] av);
		logic [14:0] h;
		case (md)
			lzhc_pkg::MODE_LOAD: hist[p[15:0]] = bv;
			lzhc_pkg::MODE_INSERT: begin
				if (av >= lzhc_pkg::MIN_RUN) begin
					h = hash3(p);
					links[p[14:0]] = heads[h];
					heads[h] = p;
				end
			end
			lzhc_pkg::MODE_FINDI: expected_matches.push_back(find_longest(p, av, 1'b1));
			lzhc_pkg::MODE_FIND: expected_matches.push_back(find_longest(p, av, 1'b0));
			lzhc_pkg::MODE_CLEAR: wipe_tables();
			default: ;
		endcase
	endfunction

	// ---------------- stimulus ----------------
	function automatic void push_item(input logic [2:0] md, input logic [31:0] p,
			input logic [7:0] bv, input logic [8:0] av);
		op_t o;
		o = '{0, 13'd0, md, p, bv, av};
		pending_ops.push_back(o);
	endfunction

	function automatic void push_cfg(input logic [12:0] v);
		op_t o;
		o = '{1, v, 3'd0, 32'd0, 8'd0, 9'd0};
		pending_ops.push_back(o);
	endfunction

	function automatic void gen_phase(input int budget, input logic [31:0] base, input bit flat);
		logic [7:0] sb[512];
		logic [7:0] b;
		logic [8:0] av;
		int ld, k, r, mx;
		ld = 0;
		push_item(lzhc_pkg::MODE_CLEAR, $urandom, 8'($urandom), 9'($urandom_range(0, 258)));
		for (int cnt = 0; cnt < budget; cnt++) begin
			r = $urandom_range(0, 99);
			if (ld < 4 || (flat && ld < 280 && r < 90) || (!flat && r < 45 && ld < 500)) begin
				if (flat)
					b = (r % 16 == 0) ? 8'($urandom) : 8'hAA;
				else if (ld > 8 && r < 20)
					b = sb[$urandom_range(ld - 8, ld - 1)];
				else if (r < 35)
					b = 8'($urandom_range(0, 3));
				else
					b = 8'($urandom);
				sb[ld] = b;
				push_item(lzhc_pkg::MODE_LOAD, base + ld, b, 9'($urandom_range(0, 258)));
				ld++;
				if (base + ld - 1 == 32'd1 && ld >= 3)
					push_item(lzhc_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'd0, 9'd3);
			end else if (r >= 95) begin
				case ($urandom_range(0, 2))
					0: push_item(3'($urandom_range(5, 7)), $urandom, 8'($urandom), 9'($urandom));
					1: push_item($urandom_range(0, 1) ? lzhc_pkg::MODE_FIND : lzhc_pkg::MODE_FINDI,
						$urandom, 8'($urandom), 9'($urandom_range(0, 2)));
					default: push_item(lzhc_pkg::MODE_INSERT, $urandom, 8'($urandom),
						9'($urandom_range(0, 2)));
				endcase
			end else begin
				k = $urandom_range(0, ld - 1);
				mx = ld - k;
				if (mx > 258) mx = 258;
				if (mx < 3)
					av = 9'(mx);
				else if (flat && $urandom_range(0, 1))
					av = 9'($urandom_range(mx > 6 ? mx - 3 : 3, mx));
				else
					av = 9'($urandom_range(3, (mx > 12 && $urandom_range(0, 3) != 0) ? 12 : mx));
				if (r < 60)
					push_item(lzhc_pkg::MODE_INSERT, base + k, 8'($urandom), av);
				else if (r < 85)
					push_item(lzhc_pkg::MODE_FINDI, base + k, 8'($urandom), av);
				else
					push_item(lzhc_pkg::MODE_FIND, base + k, 8'($urandom), av);
			end
		end
		// self candidate: insert then search the same position
		push_item(lzhc_pkg::MODE_FINDI, base + ld - 3, 8'd0, 9'd3);
		push_item(lzhc_pkg::MODE_FIND, base + ld - 3, 8'd0, 9'd3);
	endfunction

	initial begin
		for (int i = 0; i < lzhc_pkg::HISTORY_BYTES_D; i++) hist[i] = 8'd0;
		wipe_tables();
		push_item(3'd5, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
		push_item(3'd6, 32'd0, 8'd0, 9'd0);
		push_item(3'd7, 32'hA5A5_5A5A, 8'h5A, 9'd258);
		push_item(lzhc_pkg::MODE_FIND, 32'hFFFF_FFFF, 8'hFF, 9'd0);
		push_item(lzhc_pkg::MODE_FINDI, 32'd0, 8'd0, 9'd2);
		push_item(lzhc_pkg::MODE_INSERT, 32'h5555_5555, 8'd0, 9'd1);
		push_item(lzhc_pkg::MODE_LOAD, 32'hFFFF_FFFF, 8'hFF, 9'd258);
		push_item(lzhc_pkg::MODE_LOAD, 32'h8000_0000, 8'h00, 9'd0);
		gen_phase(80, 32'd0, 0);
		push_cfg(13'd0);
		gen_phase(60, 32'hFFFF_FFF0, 0);
		push_cfg(13'd1);
		gen_phase(300, $urandom, 1);
		push_cfg(13'd8191);
		gen_phase(70, $urandom, 0);
		push_cfg(13'd4096);
		gen_phase(70, 32'h7FFF_FF00, 0);
		push_cfg(13'd3);
		gen_phase(60, $urandom, 0);
		gen_done = 1;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// ---------------- driver ----------------
	int burst_left = 0;
	int gap_left = 0;
	int quiet = 0;

	always @(negedge clk) begin
		logic nv, ncv;
		op_t o;
		nv = in_valid;
		ncv = cfg_valid;
		if (arst_n && gen_done) begin
			if (in_took) nv = 1'b0;
			if (cfg_took) ncv = 1'b0;
			if (!nv && !ncv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					o = pending_ops[0];
					if (o.is_cfg) begin
						if (expected_matches.size() != 0) begin
							quiet = 0;
						end else if (quiet < 64) begin
							quiet++;
						end else begin
							void'(pending_ops.pop_front());
							cfg_data <= o.chain_cap;
							ncv = 1'b1;
							quiet = 0;
						end
					end else begin
						void'(pending_ops.pop_front());
						mode <= o.md;
						position <= o.pos;
						byte_value <= o.bv;
						available <= o.av;
						nv = 1'b1;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
							gap_left = $urandom_range(0, 6);
						end
					end
				end else begin
					sent_all = 1;
				end
			end
		end
		in_valid <= nv;
		cfg_valid <= ncv;
	end

	// ---------------- receiver ----------------
	int stall_seg = 0;
	int stall_kind = 0;
	int long_hold = 0;
	bit held_once = 0;
	int seen = 0;

	always @(negedge clk) begin
		logic rdy;
		if (out_valid && out_ready) seen++;
		if (!held_once && seen >= 40 && out_valid) begin
			held_once = 1;
			long_hold = 4000;
		end
		if (stall_seg == 0) begin
			stall_seg = $urandom_range(5, 80);
			stall_kind = $urandom_range(0, 2);
		end
		stall_seg--;
		case (stall_kind)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			default: rdy = ($urandom_range(0, 3) == 0);
		endcase
		if (long_hold > 0) begin
			long_hold--;
			rdy = 1'b0;
		end
		out_ready <= rdy;
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		match_t e;
		in_took <= in_valid && in_ready;
		cfg_took <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) chain_cap = cfg_data;
			if (in_valid && in_ready) apply_item(mode, position, byte_value, available);
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_matches.pop_front();
					if (found !== e.found) begin
						$error("found: expected %0d actual %0d", e.found, found);
						errors++;
					end
					if (match_len !== e.len) begin
						$error("match_len: expected %0d actual %0d", e.len, match_len);
						errors++;
					end
					if (match_distance !== e.mdist) begin
						$error("match_distance: expected %0d actual %0d", e.mdist, match_distance);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		wait (sent_all && expected_matches.size() == 0);
		repeat (400) @(posedge clk);
		if (expected_matches.size() != 0) errors++;
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end
endmodule
